[hdl/pif_pkg.sv]
// Shared types and constants of the polyphase interpolator FIR.
package pif_pkg;

  // Coefficient store geometry, fixed by the 7-bit prototype tap index.
  localparam int COEF_AW    = 7;
  localparam int COEF_DEPTH = 1 << COEF_AW;

  // Item modes.
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OS_RATIO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_SIZE = 1'b1;
  localparam int CFG_DATA_W = 5;

  // Reset values of the configuration registers.
  localparam logic [3:0] OS_RATIO_RST  = 4'd4;
  localparam logic [4:0] BANK_SIZE_RST = 5'd5;

  // Input transaction payload.
  typedef struct packed {
    logic               mode;
    logic [6:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample_in;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [2:0]         phase;
    logic               last;
  } out_item_t;

  // Tag that travels with each product through the MAC pipeline.
  typedef struct packed {
    logic       zero;    // sample slot not yet filled, product is zero
    logic       first;   // first tap of a phase, restarts the accumulator
    logic       last;    // last tap of a phase, result is complete
    logic       is_end;  // last tap of the last phase of the sample
    logic [2:0] phase;
  } tap_tag_t;

  // Issue sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

endpackage

[hdl/pif_mac.sv]
// Multiply-accumulate pipeline with rounding, saturation and output register.
module pif_mac import pif_pkg::*; #(
  parameter int MAX_BANK       = 16,
  parameter int COEF_FRAC_BITS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  input  logic signed [15:0] s1_coef_i,
  input  logic signed [15:0] s1_sample_i,
  input  tap_tag_t           s1_tag_i,
  output logic               hold_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o
);

  localparam int ACC_W = 34 + $clog2(MAX_BANK + 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = 32767;
  localparam logic signed [ACC_W-1:0] SAT_LO = -32768;
  localparam logic signed [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << COEF_FRAC_BITS) - 1;

  logic                      s2_valid_q;
  logic signed [31:0]        prod_q;
  logic signed [31:0]        prod_d;
  tap_tag_t                  s2_tag_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   sum;
  logic                      fin_valid_q;
  logic signed [ACC_W-1:0]   fin_q;
  tap_tag_t                  fin_tag_q;
  logic signed [ACC_W-1:0]   bias;
  logic signed [ACC_W-1:0]   quot;
  logic signed [15:0]        sat;
  logic                      out_valid_q;
  out_item_t                 out_q;

  // The whole pipeline freezes while a finished result waits to be taken.
  assign hold_o = out_valid_q && !out_ready_i;

  // Product of one tap, forced to zero for empty delay slots.
  assign prod_d = s1_tag_i.zero ? 32'sd0 : s1_coef_i * s1_sample_i;

  // Running sum, restarted at the first tap of each phase.
  assign sum = (s2_tag_q.first ? '0 : acc_q) + ACC_W'(prod_q);

  // Shift toward zero: negative sums get a bias before the arithmetic shift.
  assign bias = fin_q[ACC_W-1] ? FRAC_MASK : '0;
  assign quot = (fin_q + bias) >>> COEF_FRAC_BITS;

  always_comb begin
    if (quot > SAT_HI) begin
      sat = 16'sh7fff;
    end else if (quot < SAT_LO) begin
      sat = -16'sh8000;
    end else begin
      sat = quot[15:0];
    end
  end

  // Control state of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (!hold_o) begin
      s2_valid_q  <= s1_valid_i;
      fin_valid_q <= s2_valid_q && s2_tag_q.last;
      out_valid_q <= fin_valid_q;
    end
  end

  // Datapath registers of the pipeline stages.
  always_ff @(posedge clk_i) begin
    if (!hold_o) begin
      prod_q    <= prod_d;
      s2_tag_q  <= s1_tag_i;
      if (s2_valid_q) begin
        acc_q <= sum;
      end
      fin_q     <= sum;
      fin_tag_q <= s2_tag_q;
      out_q.sample_out <= sat;
      out_q.phase      <= fin_tag_q.phase;
      out_q.last       <= fin_tag_q.is_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/polyphase_interpolator_fir.sv]
// Top level of the polyphase interpolator FIR: memories, tap sequencer, MAC.
//
// Usage: input transactions carry either a coefficient (mode 0), stored at
// prototype index n as tap n div ratio of branch n mod ratio, or a sample
// (mode 1). A sample enters a circular delay line and yields os_ratio output
// transactions, one per branch in branch order, the final one flagged last.
// Coefficients must be loaded before samples that use them.
// A coefficient is accepted without leaving the idle state. A sample holds the
// input until all os_ratio * bank_size taps are issued, set by the single
// shared multiplier that reads one coefficient and one delay slot per cycle
// while the output does not stall.
// Configuration writes take effect at the next accepted sample and belong in idle periods.
// Reset empties the delay line through a fill count, so unfilled slots read
// as zero; coefficients are undefined until written.
// When the receiver stalls, the MAC pipeline and the tap sequencer freeze
// and resume without loss once the waiting result is taken.
module polyphase_interpolator_fir import pif_pkg::*; #(
  parameter int MAX_RATIO      = 8,
  parameter int MAX_BANK       = 16,
  parameter int COEF_FRAC_BITS = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int PTR_W = (MAX_BANK > 1) ? $clog2(MAX_BANK) : 1;
  localparam int SUM_W = PTR_W + 1;
  localparam int TAP_W = $clog2(MAX_BANK + 1);
  localparam int RAT_W = $clog2(MAX_RATIO + 1);

  logic [3:0]         os_ratio_q;
  logic [4:0]         bank_size_q;
  state_e             state_q, state_d;
  logic [PTR_W-1:0]   wp_q;
  logic [TAP_W-1:0]   count_q;
  logic [PTR_W-1:0]   start_q;
  logic [PTR_W-1:0]   start_d;
  logic [SUM_W-1:0]   start_sum;
  logic [RAT_W-1:0]   ratio_q, ratio_c;
  logic [TAP_W-1:0]   taps_q, taps_c;
  logic [RAT_W-1:0]   p_q;
  logic [TAP_W-1:0]   k_q;
  logic [TAP_W-1:0]   age_q;
  logic [COEF_AW-1:0] c_addr_q;
  logic [PTR_W-1:0]   d_addr_q;
  logic               accept;
  logic               hold;
  logic               issue;
  logic               tap_end;
  logic               phase_end;
  tap_tag_t           tag_d;

  logic signed [15:0] coef_mem [COEF_DEPTH];
  logic signed [15:0] dl_mem [MAX_BANK];
  logic signed [15:0] coef_rd_q;
  logic signed [15:0] dl_rd_q;
  tap_tag_t           s1_tag_q;
  logic               s1_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_ratio_q  <= OS_RATIO_RST;
      bank_size_q <= BANK_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_OS_RATIO:  os_ratio_q  <= cfg_wdata_i[3:0];
        CFG_BANK_SIZE: bank_size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Registers saturated into their legal ranges.
  always_comb begin
    if (os_ratio_q == 4'd0) begin
      ratio_c = RAT_W'(1);
    end else if (32'(os_ratio_q) > MAX_RATIO) begin
      ratio_c = RAT_W'(MAX_RATIO);
    end else begin
      ratio_c = RAT_W'(os_ratio_q);
    end
    if (bank_size_q == 5'd0) begin
      taps_c = TAP_W'(1);
    end else if (32'(bank_size_q) > MAX_BANK) begin
      taps_c = TAP_W'(MAX_BANK);
    end else begin
      taps_c = TAP_W'(bank_size_q);
    end
  end

  // Slot of the oldest sample in the window once the new sample is in.
  assign start_sum = SUM_W'(wp_q) + SUM_W'(MAX_BANK) - SUM_W'(taps_c - TAP_W'(1));
  assign start_d   = (start_sum >= SUM_W'(MAX_BANK)) ?
                     PTR_W'(start_sum - SUM_W'(MAX_BANK)) : PTR_W'(start_sum);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_RUN) && !hold;
  assign tap_end    = (k_q == taps_q - TAP_W'(1));
  assign phase_end  = (p_q == ratio_q - RAT_W'(1));

  // Sequencer state transitions.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_data_i.mode == MODE_SAMPLE) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && tap_end && phase_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Tag of the tap being read this cycle.
  always_comb begin
    tag_d.zero   = (age_q >= count_q);
    tag_d.first  = (k_q == '0);
    tag_d.last   = tap_end;
    tag_d.is_end = tap_end && phase_end;
    tag_d.phase  = 3'(p_q);
  end

  // Sequencer control: write pointer, fill count and tap counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wp_q     <= '0;
      count_q  <= '0;
      p_q      <= '0;
      k_q      <= '0;
      age_q    <= '0;
      c_addr_q <= '0;
      d_addr_q <= '0;
      start_q  <= '0;
      ratio_q  <= RAT_W'(1);
      taps_q   <= TAP_W'(1);
    end else begin
      state_q <= state_d;
      if (accept && in_data_i.mode == MODE_SAMPLE) begin
        wp_q     <= (wp_q == PTR_W'(MAX_BANK - 1)) ? '0 : wp_q + 1'b1;
        if (count_q != TAP_W'(MAX_BANK)) begin
          count_q <= count_q + 1'b1;
        end
        start_q  <= start_d;
        d_addr_q <= start_d;
        ratio_q  <= ratio_c;
        taps_q   <= taps_c;
        p_q      <= '0;
        k_q      <= '0;
        age_q    <= taps_c - TAP_W'(1);
        c_addr_q <= '0;
      end else if (issue) begin
        if (tap_end) begin
          p_q      <= p_q + 1'b1;
          k_q      <= '0;
          age_q    <= taps_q - TAP_W'(1);
          c_addr_q <= COEF_AW'(p_q + 1'b1);
          d_addr_q <= start_q;
        end else begin
          k_q      <= k_q + 1'b1;
          age_q    <= age_q - 1'b1;
          c_addr_q <= c_addr_q + COEF_AW'(ratio_q);
          d_addr_q <= (d_addr_q == PTR_W'(MAX_BANK - 1)) ? '0 : d_addr_q + 1'b1;
        end
      end
    end
  end

  // Coefficient memory: written by load transactions, read once per tap.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.mode == MODE_COEF) begin
      coef_mem[in_data_i.coef_index] <= in_data_i.coef_value;
    end
    if (issue) begin
      coef_rd_q <= coef_mem[c_addr_q];
    end
  end

  // Delay line memory: circular, written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.mode == MODE_SAMPLE) begin
      dl_mem[wp_q] <= in_data_i.sample_in;
    end
    if (issue) begin
      dl_rd_q  <= dl_mem[d_addr_q];
      s1_tag_q <= tag_d;
    end
  end

  // Read stage valid flag, frozen together with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!hold) begin
      s1_valid_q <= (state_q == ST_RUN);
    end
  end

  pif_mac #(
    .MAX_BANK       (MAX_BANK),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .s1_coef_i   (coef_rd_q),
    .s1_sample_i (dl_rd_q),
    .s1_tag_i    (s1_tag_q),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
